[rtl/core/b58e_pkg.sv]
package b58e_pkg;

   // Field widths of one fold step: a stored digit, the running carry, and digit * 256 + carry
   localparam int DIGIT_W = 6;
   localparam int CARRY_W = 8;
   localparam int FOLD_W  = DIGIT_W + CARRY_W;
   localparam int BYTE_W  = 8;
   localparam int CHAR_W  = 7;

   // Radix and its fixed-point reciprocal (floor of 2^16 / 58)
   localparam int RADIX       = 58;
   localparam int RECIP       = 1129;
   localparam int RECIP_W     = 11;
   localparam int RECIP_SHIFT = 16;

   // ASCII code of the character that stands for a leading zero byte
   localparam logic [CHAR_W-1:0] CHAR_ONE = 7'd49;

   // Map one base-58 digit onto the alphabet, which skips 0, I, O and l
   function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] d;
      logic [CHAR_W-1:0] code;
      d = CHAR_W'(digit);
      if (d < 7'd9) begin
         code = 7'd49 + d;
      end else if (d < 7'd17) begin
         code = 7'd65 + (d - 7'd9);
      end else if (d < 7'd22) begin
         code = 7'd74 + (d - 7'd17);
      end else if (d < 7'd33) begin
         code = 7'd80 + (d - 7'd22);
      end else if (d < 7'd44) begin
         code = 7'd97 + (d - 7'd33);
      end else begin
         code = 7'd109 + (d - 7'd44);
      end
      return code;
   endfunction

endpackage

[rtl/core/b58e_digit_ram.sv]
module b58e_digit_ram #(
   parameter int DEPTH = 45,
   parameter int AW    = 6
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [b58e_pkg::DIGIT_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [b58e_pkg::DIGIT_W-1:0] rd_data
);
   import b58e_pkg::*;

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   // Write one digit, read one digit with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/b58e_div58.sv]
module b58e_div58 (
   input  logic [b58e_pkg::FOLD_W-1:0]  value,
   output logic [b58e_pkg::CARRY_W-1:0] quotient,
   output logic [b58e_pkg::DIGIT_W-1:0] remainder
);
   import b58e_pkg::*;

   localparam int PROD_W = FOLD_W + RECIP_W;
   localparam int QE_W   = PROD_W - RECIP_SHIFT;
   localparam int REM_W  = FOLD_W + 1;

   logic [PROD_W-1:0] prod;
   logic [QE_W-1:0]   q_est;
   logic [REM_W-1:0]  r_est;
   logic [REM_W-1:0]  back;

   // Estimate the quotient low by at most one, then correct once
   always_comb begin
      prod  = PROD_W'(value) * PROD_W'(RECIP);
      q_est = prod[PROD_W-1:RECIP_SHIFT];
      back  = REM_W'(q_est) * REM_W'(RADIX);
      r_est = REM_W'(value) - back;
      if (r_est >= REM_W'(RADIX)) begin
         remainder = DIGIT_W'(r_est - REM_W'(RADIX));
         quotient  = CARRY_W'(q_est + QE_W'(1));
      end else begin
         remainder = DIGIT_W'(r_est);
         quotient  = CARRY_W'(q_est);
      end
   end

endmodule

[rtl/core/base58_encoder.sv]
// Base58 encoder: bytes come in one word per cycle while req_ready is high, most significant
// first, with req_last_byte on the final one. Leading zero bytes are only counted. Every later
// byte is folded into a base-58 digit memory, one stored digit per cycle through a single
// divide-by-58 unit; after a fold the digit count is at most 44 with 32 bytes. After the last
// byte the encoder sends one '1' per leading zero byte and then the digits that fit, most
// significant first, at up to one character per cycle while rsp_ready allows. After the last
// byte S_PREP sizes the output, S_ZERO loads the '1' characters and S_DIG the digits; the
// step from S_ZERO to S_DIG loads no character. rsp_last_char marks the final character and
// rsp_too_long is set on every character of a string that lost bytes or digits for capacity.
// No new byte is taken until the string's output has been handed off to the result register.
module base58_encoder #(
   parameter int MAX_BYTES   = 32,
   parameter int DIGIT_SLOTS = 45
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [b58e_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                        req_last_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [b58e_pkg::CHAR_W-1:0] rsp_char_code,
   output logic                        rsp_last_char,
   output logic                        rsp_too_long
);
   import b58e_pkg::*;

   localparam int BW = $clog2(MAX_BYTES + 1);
   localparam int CW = $clog2(DIGIT_SLOTS + 1);
   localparam int AW = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
   localparam int TW = ((BW > CW) ? BW : CW) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FOLD,
      S_PREP,
      S_ZERO,
      S_DIG
   } state_type;

   state_type         state_ff, state_in;
   logic [BW-1:0]     byte_cnt_ff, byte_cnt_in;
   logic [BW-1:0]     zero_cnt_ff, zero_cnt_in;
   logic [CW-1:0]     dig_cnt_ff, dig_cnt_in;
   logic              seen_ff, seen_in;
   logic              ovf_ff, ovf_in;
   logic              last_ff, last_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [BW-1:0]     zero_left_ff, zero_left_in;
   logic [CW-1:0]     dig_left_ff, dig_left_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_long_ff, rsp_long_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DIGIT_W-1:0] wr_data;
   logic               rd_en;
   logic [CW-1:0]      rd_ptr;
   logic [DIGIT_W-1:0] rd_data;

   logic [FOLD_W-1:0]  div_value;
   logic [CARRY_W-1:0] div_quo;
   logic [DIGIT_W-1:0] div_rem;

   logic               out_free;
   logic               have_dig;
   logic               fold_go;
   logic [TW-1:0]      sum_t, tot_t, zl_t, dl_t;

   b58e_digit_ram #(
      .DEPTH (DIGIT_SLOTS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (rd_data)
   );

   b58e_div58 u_div (
      .value     (div_value),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Fold operand: stored digit (zero past the top) above the carry
   assign have_dig  = pos_ff < dig_cnt_ff;
   assign fold_go   = (have_dig || carry_ff != '0) && (pos_ff < CW'(DIGIT_SLOTS));
   assign div_value = {(have_dig ? rd_data : DIGIT_W'(0)), carry_ff};

   // Length arithmetic for the output phase
   assign sum_t = TW'(zero_cnt_ff) + TW'(dig_cnt_ff);
   assign tot_t = (sum_t > TW'(DIGIT_SLOTS)) ? TW'(DIGIT_SLOTS) : sum_t;
   assign zl_t  = (TW'(zero_cnt_ff) < tot_t) ? TW'(zero_cnt_ff) : tot_t;
   assign dl_t  = tot_t - zl_t;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rd_en     = rd_ptr < CW'(DIGIT_SLOTS);

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      byte_cnt_in  = byte_cnt_ff;
      zero_cnt_in  = zero_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      seen_in      = seen_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      carry_in     = carry_ff;
      pos_in       = pos_ff;
      zero_left_in = zero_left_ff;
      dig_left_in  = dig_left_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_long_in  = rsp_long_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AW-1:0];
      wr_data      = div_rem;
      rd_ptr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            // Take a byte: count a leading zero, fold it, or drop it past capacity
            if (req_valid) begin
               last_in = req_last_byte;
               if (byte_cnt_ff < BW'(MAX_BYTES)) begin
                  byte_cnt_in = byte_cnt_ff + BW'(1);
                  if (!seen_ff && req_data_byte == '0) begin
                     zero_cnt_in = zero_cnt_ff + BW'(1);
                     state_in    = req_last_byte ? S_PREP : S_IDLE;
                  end else begin
                     seen_in  = 1'b1;
                     carry_in = req_data_byte;
                     pos_in   = '0;
                     state_in = S_FOLD;
                  end
               end else begin
                  ovf_in   = 1'b1;
                  state_in = req_last_byte ? S_PREP : S_IDLE;
               end
            end
         end

         S_FOLD: begin
            // Rewrite one digit per cycle and prefetch the next
            if (fold_go) begin
               wr_en    = 1'b1;
               carry_in = div_quo;
               pos_in   = pos_ff + CW'(1);
               rd_ptr   = pos_ff + CW'(1);
            end else begin
               dig_cnt_in = pos_ff;
               if (carry_ff != '0) begin
                  ovf_in = 1'b1;
               end
               state_in = last_ff ? S_PREP : S_IDLE;
            end
         end

         S_PREP: begin
            // Size the output and cap it at the digit capacity
            if (sum_t > TW'(DIGIT_SLOTS)) begin
               ovf_in = 1'b1;
            end
            zero_left_in = zl_t[BW-1:0];
            dig_left_in  = dl_t[CW-1:0];
            idx_in       = dig_cnt_ff - CW'(1);
            state_in     = S_ZERO;
         end

         S_ZERO: begin
            // Send the '1' characters while the top digit is fetched
            rd_ptr = idx_ff;
            if (zero_left_ff == '0) begin
               state_in = S_DIG;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ONE;
               rsp_last_in  = (zero_left_ff == BW'(1)) && (dig_left_ff == '0);
               rsp_long_in  = ovf_ff;
               zero_left_in = zero_left_ff - BW'(1);
            end
         end

         S_DIG: begin
            // Send digits top down, holding the read address while stalled
            rd_ptr = idx_ff;
            if (dig_left_ff == '0) begin
               byte_cnt_in = '0;
               zero_cnt_in = '0;
               dig_cnt_in  = '0;
               seen_in     = 1'b0;
               ovf_in      = 1'b0;
               last_in     = 1'b0;
               state_in    = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = b58_char(rd_data);
               rsp_last_in  = (dig_left_ff == CW'(1));
               rsp_long_in  = ovf_ff;
               dig_left_in  = dig_left_ff - CW'(1);
               idx_in       = idx_ff - CW'(1);
               rd_ptr       = idx_ff - CW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         byte_cnt_ff  <= '0;
         zero_cnt_ff  <= '0;
         dig_cnt_ff   <= '0;
         seen_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         pos_ff       <= '0;
         zero_left_ff <= '0;
         dig_left_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_cnt_ff  <= byte_cnt_in;
         zero_cnt_ff  <= zero_cnt_in;
         dig_cnt_ff   <= dig_cnt_in;
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         pos_ff       <= pos_in;
         zero_left_ff <= zero_left_in;
         dig_left_ff  <= dig_left_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      carry_ff    <= carry_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_long_ff <= rsp_long_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
   assign rsp_too_long  = rsp_long_ff;

endmodule

[dv/tb.sv]
module tb;
   import b58e_pkg::*;

   localparam int MAX_BYTES    = 32;
   localparam int DIGIT_SLOTS  = 45;
   localparam int RANDOM_BYTES = 200;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 400000;

   // One expected character word
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last_char;
      logic              too_long;
   } b58_char_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAR_W-1:0] rsp_char_code;
   logic              rsp_last_char;
   logic              rsp_too_long;

   // Encoder shadow state for the string in flight
   logic [DIGIT_W-1:0] shadow_digits [DIGIT_SLOTS];
   int unsigned        shadow_digit_count = 0;
   int unsigned        shadow_zero_count  = 0;
   int unsigned        shadow_byte_count  = 0;
   bit                 shadow_nonzero     = 1'b0;
   bit                 shadow_lost        = 1'b0;
   string              b58_alphabet =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   b58_char_type expected_chars [$];
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   bit          req_calm    = 1'b0;
   bit          rsp_calm    = 1'b0;
   bit          hold_go     = 1'b0;
   logic        rsp_hold    = 1'b0;

   base58_encoder #(
      .MAX_BYTES  (MAX_BYTES),
      .DIGIT_SLOTS(DIGIT_SLOTS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last_char(rsp_last_char),
      .rsp_too_long (rsp_too_long)
   );

   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // Fold one accepted byte into the shadow digits; on the last byte queue the encoded string
   task automatic encode_byte(input logic [BYTE_W-1:0] data, input logic is_last);
      int unsigned carry;
      int unsigned j;
      int unsigned total;
      int unsigned k;
      byte unsigned ch;
      b58_char_type c;
      if (shadow_byte_count < MAX_BYTES) begin
         shadow_byte_count++;
         if (!shadow_nonzero && data == 0) begin
            shadow_zero_count++;
         end else begin
            shadow_nonzero = 1'b1;
            carry = data;
            j = 0;
            while ((j < shadow_digit_count || carry != 0) && j < DIGIT_SLOTS) begin
               if (j < shadow_digit_count)
                  carry += 256 * shadow_digits[j];
               shadow_digits[j] = DIGIT_W'(carry % RADIX);
               carry /= RADIX;
               j++;
            end
            if (carry != 0)
               shadow_lost = 1'b1;
            shadow_digit_count = j;
         end
      end else begin
         shadow_lost = 1'b1;
      end
      if (!is_last)
         return;
      total = shadow_zero_count + shadow_digit_count;
      if (total > DIGIT_SLOTS) begin
         total = DIGIT_SLOTS;
         shadow_lost = 1'b1;
      end
      // Leading zero bytes first, then digits from the top down
      for (k = 0; k < total; k++) begin
         if (k < shadow_zero_count) begin
            c.code = CHAR_ONE;
         end else begin
            ch = b58_alphabet[shadow_digits[shadow_digit_count - 1 - (k - shadow_zero_count)]];
            c.code = ch[CHAR_W-1:0];
         end
         c.last_char = (k + 1 == total);
         c.too_long  = shadow_lost;
         expected_chars.insert(expected_chars.size(), c);
      end
      shadow_digit_count = 0;
      shadow_zero_count  = 0;
      shadow_byte_count  = 0;
      shadow_nonzero     = 1'b0;
      shadow_lost        = 1'b0;
   endtask

   // Offer one word after a random gap and hold it until the encoder takes it
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic is_last);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= is_last;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      encode_byte(data, is_last);
   endtask

   // Take result words with random stalls and compare against the oldest expectation
   initial begin : char_checker
      int           stall;
      b58_char_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0)
            rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 4);
         if (stall > 0 || rsp_hold) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %0d", rsp_char_code));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.code)
               report_mismatch($sformatf("char_code got %0d expected %0d",
                                         rsp_char_code, want.code));
            if (rsp_last_char !== want.last_char)
               report_mismatch($sformatf("last_char got %0b expected %0b",
                                         rsp_last_char, want.last_char));
            if (rsp_too_long !== want.too_long)
               report_mismatch($sformatf("too_long got %0b expected %0b",
                                         rsp_too_long, want.too_long));
         end
      end
   end

   // Hold off the result side for a long stretch once asked
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // One-byte strings: zero, one, top value, a low-order zero digit, the top digit
   task automatic test_single_bytes();
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h3A, 1'b1);
      send_byte(8'h39, 1'b1);
   endtask

   // Leading zero bytes, zeros after the first nonzero byte, and an all-zero string
   task automatic test_zero_prefix();
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // Fill to capacity with the top value and end on a byte that is dropped
   task automatic test_capacity();
      for (int i = 0; i < MAX_BYTES + 2; i++)
         send_byte(8'hFF, i == MAX_BYTES + 1);
   endtask

   // Keep offering words while the result side is held off
   task automatic test_pressure();
      req_calm = 1'b1;
      hold_go  = 1'b1;
      for (int s = 0; s < 3; s++)
         for (int i = 0; i < 6; i++)
            send_byte(i == 0 ? 8'($urandom_range(128, 255)) : 8'($urandom()), i == 5);
      req_calm = 1'b0;
   endtask

   // Random strings: mostly short, some long, a few past capacity
   task automatic test_random();
      int sent;
      int len;
      int lead;
      int pick;
      logic [BYTE_W-1:0] data;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         req_calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick < 16)
            len = $urandom_range(1, 8);
         else if (pick < 19)
            len = $urandom_range(9, MAX_BYTES);
         else
            len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
         lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         if (lead > len)
            lead = len;
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 7);
            if (i < lead || pick == 0)
               data = 8'h00;
            else if (pick == 1)
               data = 8'hFF;
            else
               data = 8'($urandom());
            send_byte(data, i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_single_bytes();
      test_zero_prefix();
      test_capacity();
      test_pressure();
      test_random();
      req_valid <= 1'b0;
      // Drain outstanding characters, then watch for strays
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/b58e_pkg.sv
rtl/core/b58e_digit_ram.sv
rtl/core/b58e_div58.sv
rtl/core/base58_encoder.sv
dv/tb.sv
